// ===== sv/uuidp_pkg.sv =====
// ----------------------------------------------------------------------------
// uuidp_pkg
// Shared types, constants and the character classifier for the UUID text
// parser.
// ----------------------------------------------------------------------------
package uuidp_pkg;

  localparam int unsigned CountW = 6;

  localparam logic [CountW-1:0] HexLen    = 6'd32;
  localparam logic [CountW-1:0] DashedLen = 6'd36;
  localparam logic [CountW-1:0] CountMax  = 6'd37;
  localparam logic [CountW-1:0] DashPos0  = 6'd8;
  localparam logic [CountW-1:0] DashPos1  = 6'd13;
  localparam logic [CountW-1:0] DashPos2  = 6'd18;
  localparam logic [CountW-1:0] DashPos3  = 6'd23;

  localparam logic [7:0] DashChar  = 8'h2D;
  localparam logic [7:0] Digit0    = 8'h30;
  localparam logic [7:0] Digit9    = 8'h39;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerF    = 8'h66;
  localparam logic [7:0] UpperA    = 8'h41;
  localparam logic [7:0] UpperF    = 8'h46;
  localparam logic [7:0] AlphaBase = 8'd10;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [63:0] value_high;
    logic [63:0] value_low;
  } out_item_t;

  // classified character as it travels from front to back
  typedef struct packed {
    logic       hex;
    logic       dash;
    logic [3:0] digit;
    logic       last;
  } cls_item_t;

  function automatic cls_item_t classify(input in_item_t item);
    cls_item_t  c;
    logic [7:0] ch;
    logic [7:0] val;
    ch      = item.char_code;
    val     = 8'd0;
    c.hex   = 1'b1;
    if ((ch >= Digit0) && (ch <= Digit9)) begin
      val = ch - Digit0;
    end else if ((ch >= LowerA) && (ch <= LowerF)) begin
      val = ch - LowerA + AlphaBase;
    end else if ((ch >= UpperA) && (ch <= UpperF)) begin
      val = ch - UpperA + AlphaBase;
    end else begin
      c.hex = 1'b0;
    end
    c.digit = val[3:0];
    c.dash  = (ch == DashChar);
    c.last  = item.last;
    return c;
  endfunction

endpackage

// ===== sv/uuidp_front.sv =====
// ----------------------------------------------------------------------------
// uuidp_front
// Accepts characters and registers their classification (hex digit value,
// dash, last flag) for the back end.
// ----------------------------------------------------------------------------
module uuidp_front import uuidp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      cls_vld_o,
  output cls_item_t cls_item_o,
  input  logic      cls_rdy_i
);

  logic      vld_q, vld_d;
  cls_item_t cls_q;
  logic      take;

  assign full  = vld_q && !cls_rdy_i;
  assign take  = push && !full;
  assign vld_d = take || (vld_q && !cls_rdy_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= classify(in_item_i);
    end
  end

  assign cls_vld_o  = vld_q;
  assign cls_item_o = cls_q;

endmodule

// ===== sv/uuidp_fifo.sv =====
// ----------------------------------------------------------------------------
// uuidp_fifo
// Two-entry queue of classified characters between front and back end.
// ----------------------------------------------------------------------------
module uuidp_fifo import uuidp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_vld_i,
  output logic      wr_rdy_o,
  input  cls_item_t wr_item_i,
  output logic      rd_vld_o,
  input  logic      rd_en_i,
  output cls_item_t rd_item_o
);

  cls_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en;

  assign wr_rdy_o = (cnt_q != 2'd2);
  assign rd_vld_o = (cnt_q != 2'd0);
  assign wr_en    = wr_vld_i && wr_rdy_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !(rd_en_i && rd_vld_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!wr_en && rd_en_i && rd_vld_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en_i && rd_vld_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ===== sv/uuidp_back.sv =====
// ----------------------------------------------------------------------------
// uuidp_back
// Tracks position and format flags, shifts hex digits into the 128-bit value
// and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module uuidp_back import uuidp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cls_vld_i,
  output logic      cls_rd_o,
  input  cls_item_t cls_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [63:0]       hi_q, hi_d, lo_q, lo_d;
  logic              dash_ok_q, dash_ok_d;
  logic              other_hex_q, other_hex_d;
  logic              all_hex_q, all_hex_d;
  logic              out_vld_q, out_vld_d;
  out_item_t         out_q;
  logic              dash_pos, ok, room, take;

  assign room     = !out_vld_q || pop;
  assign take     = cls_vld_i && (!cls_item_i.last || room);
  assign cls_rd_o = take;

  // a new result wins over the pop of the old one
  assign out_vld_d = (take && cls_item_i.last) || (out_vld_q && !pop);

  always_comb begin
    dash_pos = (cnt_q == DashPos0) || (cnt_q == DashPos1) ||
               (cnt_q == DashPos2) || (cnt_q == DashPos3);
    all_hex_d   = all_hex_q && cls_item_i.hex;
    dash_ok_d   = dash_pos ? (dash_ok_q && cls_item_i.dash) : dash_ok_q;
    other_hex_d = dash_pos ? other_hex_q : (other_hex_q && cls_item_i.hex);
    hi_d = hi_q;
    lo_d = lo_q;
    if (cls_item_i.hex) begin
      hi_d = {hi_q[59:0], lo_q[63:60]};
      lo_d = {lo_q[59:0], cls_item_i.digit};
    end
    cnt_d = (cnt_q < CountMax) ? cnt_q + 6'd1 : cnt_q;
    ok = ((cnt_d == HexLen) && all_hex_d) ||
         ((cnt_d == DashedLen) && dash_ok_d && other_hex_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      dash_ok_q   <= 1'b1;
      other_hex_q <= 1'b1;
      all_hex_q   <= 1'b1;
      out_vld_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (take) begin
        if (cls_item_i.last) begin
          // string done: back to the idle values
          cnt_q       <= '0;
          hi_q        <= '0;
          lo_q        <= '0;
          dash_ok_q   <= 1'b1;
          other_hex_q <= 1'b1;
          all_hex_q   <= 1'b1;
        end else begin
          cnt_q       <= cnt_d;
          hi_q        <= hi_d;
          lo_q        <= lo_d;
          dash_ok_q   <= dash_ok_d;
          other_hex_q <= other_hex_d;
          all_hex_q   <= all_hex_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cls_item_i.last) begin
      out_q.status     <= !ok;
      out_q.value_high <= ok ? hi_d : 64'd0;
      out_q.value_low  <= ok ? lo_d : 64'd0;
    end
  end

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountMax)
    else $error("position count above saturation");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status) |-> (out_q.value_high == 64'd0 && out_q.value_low == 64'd0))
    else $error("failed parse carries nonzero value");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cls_item_i.last) |=> (cnt_q == '0 && out_vld_q))
    else $error("last character did not close the string");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !pop) |-> !(take && cls_item_i.last))
    else $error("waiting result overwritten");
`endif

endmodule

// ===== sv/uuid_text_parser.sv =====
// ----------------------------------------------------------------------------
// uuid_text_parser
// Parses a UUID text given one character per request into a 128-bit value.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle while full is low, with no gaps needed
// between strings. Accepts 32 hex digits or the 36-character dashed form
// (dashes at positions 8, 13, 18, 23), hex in either case. The result for a
// string (status 0 = ok, 1 = bad format, value zero on failure) passes the
// classify register and the two-entry queue on its way into the output
// register, from which it can be popped. A waiting result stalls further
// strings only once the queue in front of it fills.
module uuid_text_parser import uuidp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic      f_vld, f_rdy;
  cls_item_t f_item;
  logic      q_vld, q_rd;
  cls_item_t q_item;

  uuidp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .cls_vld_o  (f_vld),
    .cls_item_o (f_item),
    .cls_rdy_i  (f_rdy)
  );

  uuidp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_vld_i  (f_vld),
    .wr_rdy_o  (f_rdy),
    .wr_item_i (f_item),
    .rd_vld_o  (q_vld),
    .rd_en_i   (q_rd),
    .rd_item_o (q_item)
  );

  uuidp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_vld_i  (q_vld),
    .cls_rd_o   (q_rd),
    .cls_item_i (q_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ===== tb/uuid_text_parser_checker.sv =====
// ----------------------------------------------------------------------------
// uuid_text_parser_checker
// Watches both queues of the UUID text parser, works out the result for each
// string from the characters that went in, and compares every popped result
// against it in order.
// ----------------------------------------------------------------------------
module uuid_text_parser_checker import uuidp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_item_t    in_item_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned parsed_count_o,
  output int unsigned rejected_count_o
);

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  // parse state of the string in flight
  logic [CountW-1:0] char_seen  = '0;
  logic [63:0]       uuid_hi    = '0;
  logic [63:0]       uuid_lo    = '0;
  logic              dashes_ok  = 1'b1;
  logic              digits_hex = 1'b1;
  logic              all_hex    = 1'b1;

  out_item_t   uuid_expect_q[$];
  int unsigned fail_count     = 0;
  int unsigned parsed_count   = 0;
  int unsigned rejected_count = 0;

  assign fail_count_o     = fail_count;
  assign pending_o        = uuid_expect_q.size();
  assign parsed_count_o   = parsed_count;
  assign rejected_count_o = rejected_count;

  function void parse_char(input in_item_t req);
    logic [7:0] ch;
    logic [3:0] nibble;
    logic       is_hex;
    logic       dash_slot;
    logic       good;
    out_item_t  res;
    ch     = req.char_code;
    is_hex = 1'b1;
    nibble = '0;
    if (ch >= Digit0 && ch <= Digit9) begin
      nibble = 4'(ch - Digit0);
    end else if (ch >= LowerA && ch <= LowerF) begin
      nibble = 4'(ch - LowerA + AlphaBase);
    end else if (ch >= UpperA && ch <= UpperF) begin
      nibble = 4'(ch - UpperA + AlphaBase);
    end else begin
      is_hex = 1'b0;
    end
    dash_slot = (char_seen == DashPos0) || (char_seen == DashPos1) ||
                (char_seen == DashPos2) || (char_seen == DashPos3);
    if (!is_hex) all_hex = 1'b0;
    if (dash_slot) begin
      if (ch != DashChar) dashes_ok = 1'b0;
    end else if (!is_hex) begin
      digits_hex = 1'b0;
    end
    if (is_hex) {uuid_hi, uuid_lo} = {uuid_hi[59:0], uuid_lo, nibble};
    if (char_seen < CountMax) char_seen = char_seen + 1'b1;
    if (req.last) begin
      good = (char_seen == HexLen && all_hex) ||
             (char_seen == DashedLen && dashes_ok && digits_hex);
      res.status     = good ? StatusOk : StatusBad;
      res.value_high = good ? uuid_hi : 64'd0;
      res.value_low  = good ? uuid_lo : 64'd0;
      uuid_expect_q.push_back(res);
      if (good) parsed_count++;
      else rejected_count++;
      char_seen  = '0;
      uuid_hi    = '0;
      uuid_lo    = '0;
      dashes_ok  = 1'b1;
      digits_hex = 1'b1;
      all_hex    = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (push_i && !full_i) parse_char(in_item_i);
      if (pop_i && !empty_i) begin
        if (uuid_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d value %h_%h", $time,
                   out_item_i.status, out_item_i.value_high, out_item_i.value_low);
          fail_count++;
        end else begin
          want = uuid_expect_q.pop_front();
          if (out_item_i.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time,
                     want.status, out_item_i.status);
            fail_count++;
          end
          if (out_item_i.value_high !== want.value_high) begin
            $display("%0t: value_high mismatch: expected %h, got %h", $time,
                     want.value_high, out_item_i.value_high);
            fail_count++;
          end
          if (out_item_i.value_low !== want.value_low) begin
            $display("%0t: value_low mismatch: expected %h, got %h", $time,
                     want.value_low, out_item_i.value_low);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/uuid_text_parser_tb.sv =====
// ----------------------------------------------------------------------------
// uuid_text_parser_tb
// Feeds the UUID text parser with hand-picked strings and then random well
// formed, damaged and garbage strings under varying back-pressure; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module uuid_text_parser_tb;
  import uuidp_pkg::*;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      push    = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop     = 1'b0;
  out_item_t out_item;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned parsed_count;
  int unsigned rejected_count;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned chars_sent    = 0;
  int unsigned texts_sent    = 0;
  int unsigned full_stalls   = 0;
  logic [7:0]  text_buf[$];

  uuid_text_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  uuid_text_parser_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .in_item_i        (in_item),
    .empty_i          (empty),
    .pop_i            (pop),
    .out_item_i       (out_item),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .parsed_count_o   (parsed_count),
    .rejected_count_o (rejected_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4_800_000;
    $display("timeout: %0d results still outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random pops, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= req;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    chars_sent++;
  endtask

  task automatic send_text();
    in_item_t req;
    for (int i = 0; i < text_buf.size(); i++) begin
      req.char_code = text_buf[i];
      req.last      = (i == text_buf.size() - 1);
      send_request(req);
    end
    texts_sent++;
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_hex_char();
    logic [7:0] d;
    d = 8'($urandom_range(15));
    if (d < AlphaBase) return Digit0 + d;
    if ($urandom_range(1)) return LowerA + d - AlphaBase;
    return UpperA + d - AlphaBase;
  endfunction

  function automatic bit is_dash_slot(input int pos);
    return pos == DashPos0 || pos == DashPos1 || pos == DashPos2 || pos == DashPos3;
  endfunction

  task automatic build_uuid(input bit dashed);
    text_buf.delete();
    for (int i = 0; i < (dashed ? DashedLen : HexLen); i++) begin
      if (dashed && is_dash_slot(i)) text_buf.push_back(DashChar);
      else text_buf.push_back(rand_hex_char());
    end
  endtask

  task automatic build_random_text();
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    kind = $urandom_range(99);
    if (kind < 40) begin
      build_uuid(1'b1);
    end else if (kind < 68) begin
      build_uuid(1'b0);
    end else if (kind < 86) begin
      // well-formed text with one character changed, dropped or added
      build_uuid($urandom_range(1));
      pos = $urandom_range(text_buf.size() - 1);
      case ($urandom_range(4))
        0: text_buf[pos] = 8'($urandom_range(255));
        1: text_buf[pos] = DashChar;
        2: text_buf[pos] = rand_hex_char();
        3: void'(text_buf.pop_back());
        default: text_buf.push_back(rand_hex_char());
      endcase
    end else begin
      text_buf.delete();
      len = $urandom_range(45, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(9))
          0, 1:    text_buf.push_back(DashChar);
          2, 3, 4: text_buf.push_back(8'($urandom_range(255)));
          default: text_buf.push_back(rand_hex_char());
        endcase
      end
    end
  endtask

  initial begin
    logic [7:0] odd_bytes[9];
    int         pos;
    odd_bytes = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h80, 8'hFF, 8'h00};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings
    send_idle_pct = 10;
    recv_idle_pct = 10;
    load_text("0123456789abcdefABCDEF0123456789");     send_text();
    load_text("ffffffff-ffff-ffff-ffff-ffffffffffff"); send_text();
    load_text("00000000-0000-0000-0000-000000000000"); send_text();
    load_text("FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF");     send_text();
    load_text("9aF0c3e1-7B2d-4e5f-8a6B-0c1D2e3F4a5b"); send_text();
    load_text("0123456789abcdef0123456789abcde");      send_text();
    load_text("0123456789abcdef0123456789abcdef0");    send_text();
    load_text("01234567-89ab-cdef-0123-456789abcde");  send_text();
    load_text("01234567-89ab-cdef-0123-456789abcdef0"); send_text();
    load_text("0123456789abcdef0123456789abcdef0123456789ab"); send_text();
    load_text("a");                                    send_text();
    load_text("-");                                    send_text();
    // dash one place early
    load_text("0123456-789ab-cdef-0123-456789abcdef"); send_text();
    // dash inside a plain 32-digit text
    load_text("0123456789abcdef-123456789abcdef");     send_text();
    // 36 digits with no dashes
    load_text("0123456789abcdef0123456789abcdef0123"); send_text();
    // dash slot holding a digit
    load_text("01234567-89ab-cdef-0123-456789abcdef");
    text_buf[DashPos3] = Digit0;
    send_text();
    // bytes just outside the hex ranges, top-bit bytes and a zero byte at digit positions
    for (int j = 0; j < 9; j++) begin
      load_text("01234567-89ab-cdef-0123-456789abcdef");
      pos = (j * 7) % DashedLen;
      if (is_dash_slot(pos)) pos++;
      text_buf[pos] = odd_bytes[j];
      send_text();
    end

    // random strings in three back-pressure phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 28; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 2) begin
        // stop the result side while short strings keep coming
        hold_req = 1'b1;
        for (int j = 0; j < 40; j++) begin
          text_buf.delete();
          for (int k = $urandom_range(3, 1); k > 0; k--) begin
            text_buf.push_back($urandom_range(1) ? rand_hex_char() : 8'($urandom_range(255)));
          end
          send_text();
        end
      end
      while (chars_sent < 820 + 210 * (phase + 1)) begin
        build_random_text();
        send_text();
      end
    end
    push <= 1'b0;
    recv_idle_pct = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d characters in %0d strings; %0d parsed and %0d rejected results",
             chars_sent, texts_sent, parsed_count, rejected_count);
    $display("input held back by a full queue on %0d cycles", full_stalls);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
